// ===== rtl/csl_pkg.sv =====
package csl_pkg;

  // Output field widths
  localparam int unsigned TypeW     = 4;
  localparam int unsigned FieldW    = 16;
  localparam int unsigned OutDataW  = 40;
  localparam int unsigned OffsetBitsDefault = 16;

  // Character codes
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChVt     = 8'h0B;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;

  // Token type codes
  typedef enum logic [TypeW-1:0] {
    TokUnknown = 4'd0,
    TokIdent   = 4'd1,
    TokString  = 4'd2,
    TokLParen  = 4'd3,
    TokRParen  = 4'd4,
    TokColon   = 4'd5,
    TokSemi    = 4'd6,
    TokStar    = 4'd7,
    TokLBrack  = 4'd8,
    TokRBrack  = 4'd9,
    TokLBrace  = 4'd10,
    TokRBrace  = 4'd11,
    TokEnd     = 4'd12
  } tok_type_e;

  // Lexer modes, one-hot
  typedef enum logic [7:0] {
    ModeIdle   = 8'b0000_0001,
    ModeSlash  = 8'b0000_0010,
    ModeLine   = 8'b0000_0100,
    ModeBlock  = 8'b0000_1000,
    ModeBstar  = 8'b0001_0000,
    ModeIdent  = 8'b0010_0000,
    ModeStr    = 8'b0100_0000,
    ModeStrEsc = 8'b1000_0000
  } lex_mode_e;

  typedef struct packed {
    tok_type_e          ttype;
    logic [FieldW-1:0]  start;
    logic [FieldW-1:0]  length;
    logic               last;
  } tok_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChVt) || (c == ChFf) ||
           (c == ChCr) || (c == ChLf);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == ChUnder);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic tok_type_e punct_type(input logic [7:0] c);
    tok_type_e t;
    case (c)
      8'h28:   t = TokLParen;
      8'h29:   t = TokRParen;
      8'h3A:   t = TokColon;
      8'h3B:   t = TokSemi;
      ChStar:  t = TokStar;
      8'h5B:   t = TokLBrack;
      8'h5D:   t = TokRBrack;
      8'h7B:   t = TokLBrace;
      8'h7D:   t = TokRBrace;
      default: t = TokUnknown;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/c_subset_token_lexer.sv =====
// Channel   Dir  Group                     Contents
// s_axis    in   tvalid/tready/tdata[7:0]  one text byte per item
// m_axis    out  tvalid/tready/tdata/tlast one token per item, tlast on the
//                                          final token of an input byte
//
// One byte is taken per cycle, only while the buffer is empty or drains in
// that cycle; it is lexed in the cycle it is taken and its tokens land in a
// two-entry result buffer. A punctuation byte that closes a token, or an end
// byte that flushes an open token, yields two tokens and blocks input while
// the second leaves. Reset clears the lexer mode, offset and buffer count.
module c_subset_token_lexer
  import csl_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OffsetBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] ch
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [3:0] tok_kind,
                                              // [19:4] token_start,
                                              // [35:20] token_length, rest 0
  output logic                m_axis_tlast    // last
);

  localparam logic [OFFSET_BITS-1:0] OffMax = {OFFSET_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0] OneW   = OFFSET_BITS'(1);

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
    return (v == OffMax) ? OffMax : v + OneW;
  endfunction

  lex_mode_e              mode_q, mode_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [OFFSET_BITS-1:0] ps_q, ps_d;
  logic [OFFSET_BITS-1:0] pl_q, pl_d;

  tok_t       slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0] cnt_q, cnt_d;

  logic [7:0] ch;
  logic       push, pop;

  // Lexing of the byte as if from idle
  lex_mode_e              fi_mode;
  logic [OFFSET_BITS-1:0] fi_ps, fi_pl;
  logic                   fi_emit;
  tok_t                   fi_tok;

  // Tokens this byte produces
  logic [1:0] em_cnt;
  tok_t       tok_a, tok_b;

  assign ch   = s_axis_tdata;
  assign pop  = m_axis_tvalid && m_axis_tready;
  assign push = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready);
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {{(OutDataW - TypeW - 2*FieldW){1'b0}},
                          slot0_q.length, slot0_q.start, slot0_q.ttype};
  assign m_axis_tlast  = slot0_q.last;

  // Start a token from idle
  always_comb begin
    fi_mode = ModeIdle;
    fi_ps   = ps_q;
    fi_pl   = pl_q;
    fi_emit = 1'b0;
    fi_tok  = '{ttype: punct_type(ch), start: FieldW'(off_q),
                length: FieldW'(1), last: 1'b0};
    if (is_space(ch)) begin
      fi_mode = ModeIdle;
    end else if (ch == ChSlash) begin
      fi_mode = ModeSlash;
      fi_ps   = off_q;
      fi_pl   = OneW;
    end else if (is_letter(ch)) begin
      fi_mode = ModeIdent;
      fi_ps   = off_q;
      fi_pl   = OneW;
    end else if (ch == ChQuote) begin
      fi_mode = ModeStr;
      fi_ps   = sat_inc(off_q);
      fi_pl   = '0;
    end else begin
      fi_emit = 1'b1;
    end
  end

  // Lex one byte: next state and up to two tokens
  always_comb begin
    mode_d = mode_q;
    off_d  = off_q;
    ps_d   = ps_q;
    pl_d   = pl_q;
    em_cnt = 2'd0;
    tok_a  = '{ttype: TokUnknown, start: FieldW'(ps_q), length: FieldW'(1), last: 1'b0};
    tok_b  = '{ttype: TokEnd, start: FieldW'(off_q), length: FieldW'(1), last: 1'b1};
    if (ch == ChNul) begin
      // flush any open token, then emit end
      em_cnt = 2'd2;
      unique case (mode_q) inside
        ModeIdent:  tok_a = '{TokIdent, FieldW'(ps_q), FieldW'(pl_q), 1'b0};
        ModeStr,
        ModeStrEsc: tok_a = '{TokString, FieldW'(ps_q), FieldW'(pl_q), 1'b0};
        ModeSlash:  tok_a = '{TokUnknown, FieldW'(ps_q), FieldW'(1), 1'b0};
        default: begin
          em_cnt = 2'd1;
          tok_a  = tok_b;
        end
      endcase
      mode_d = ModeIdle;
      off_d  = '0;
      ps_d   = '0;
      pl_d   = '0;
    end else begin
      unique case (mode_q)
        ModeSlash: begin
          if (ch == ChSlash) begin
            mode_d = ModeLine;
          end else if (ch == ChStar) begin
            mode_d = ModeBlock;
          end else begin
            tok_a  = '{TokUnknown, FieldW'(ps_q), FieldW'(1), !fi_emit};
            tok_b  = fi_tok;
            tok_b.last = 1'b1;
            em_cnt = fi_emit ? 2'd2 : 2'd1;
            mode_d = fi_mode;
            ps_d   = fi_ps;
            pl_d   = fi_pl;
          end
        end
        ModeLine: begin
          if ((ch == ChLf) || (ch == ChCr)) mode_d = ModeIdle;
        end
        ModeBlock: begin
          if (ch == ChStar) mode_d = ModeBstar;
        end
        ModeBstar: begin
          if (ch == ChSlash) begin
            mode_d = ModeIdle;
          end else if (ch != ChStar) begin
            mode_d = ModeBlock;
          end
        end
        ModeIdent: begin
          if (is_letter(ch) || is_digit(ch)) begin
            pl_d = sat_inc(pl_q);
          end else begin
            tok_a  = '{TokIdent, FieldW'(ps_q), FieldW'(pl_q), !fi_emit};
            tok_b  = fi_tok;
            tok_b.last = 1'b1;
            em_cnt = fi_emit ? 2'd2 : 2'd1;
            mode_d = fi_mode;
            ps_d   = fi_ps;
            pl_d   = fi_pl;
          end
        end
        ModeStr: begin
          if (ch == ChQuote) begin
            tok_a  = '{TokString, FieldW'(ps_q), FieldW'(pl_q), 1'b1};
            em_cnt = 2'd1;
            mode_d = ModeIdle;
          end else begin
            if (ch == ChBslash) mode_d = ModeStrEsc;
            pl_d = sat_inc(pl_q);
          end
        end
        ModeStrEsc: begin
          pl_d   = sat_inc(pl_q);
          mode_d = ModeStr;
        end
        default: begin
          tok_a  = fi_tok;
          tok_a.last = 1'b1;
          em_cnt = fi_emit ? 2'd1 : 2'd0;
          mode_d = fi_mode;
          ps_d   = fi_ps;
          pl_d   = fi_pl;
        end
      endcase
      off_d = sat_inc(off_q);
    end
  end

  // Result buffer: load on accept, else advance on pop
  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (push) begin
      cnt_d   = em_cnt;
      slot0_d = tok_a;
      slot1_d = tok_b;
    end else if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      off_q  <= '0;
      ps_q   <= '0;
      pl_q   <= '0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        mode_q <= mode_d;
        off_q  <= off_d;
        ps_q   <= ps_d;
        pl_q   <= pl_d;
      end
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  // An item is taken only when the buffer is empty or empties in that cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop)))
    else $error("byte accepted while results still queued");

  // Two queued tokens: only the second closes the byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (!slot0_q.last && slot1_q.last))
    else $error("last flag misplaced in result buffer");

  // End of text restarts the offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && (s_axis_tdata == ChNul)) |=> (off_q == '0) && (mode_q == ModeIdle))
    else $error("offset not cleared after end of text");

endmodule
